FILE: rtl/core/csl_pkg.sv
// Package with shared constants, codes and types for the cursor sequence list.
`timescale 1ns / 1ps

package csl_pkg;

  // Default sizing of the list.
  localparam int unsigned DefCapacity  = 16;
  localparam int unsigned DefWordWidth = 32;

  // Fixed field widths of the command and result words.
  localparam int unsigned ActW    = 3;
  localparam int unsigned InWordW = 32;
  localparam int unsigned StatusW = 2;

  // Command actions.
  typedef enum logic [ActW-1:0] {
    ACT_START  = 3'd0,
    ACT_ADVANCE = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_ATTACH = 3'd3,
    ACT_REMOVE = 3'd4
  } csl_action_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    STS_OK       = 2'd0,
    STS_ADV_NONE = 2'd1,
    STS_FULL     = 2'd2,
    STS_REM_NONE = 2'd3
  } csl_status_e;

  // Operation applied to every cell of a stack together.
  typedef enum logic [1:0] {
    STK_HOLD = 2'd0,
    STK_PUSH = 2'd1,
    STK_POP  = 2'd2,
    STK_LOAD = 2'd3
  } csl_stk_op_e;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } csl_state_e;

endpackage

FILE: rtl/core/csl_if.sv
// Handshake interfaces for the command and result channels.
`timescale 1ns / 1ps

interface csl_cmd_if import csl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ActW-1:0]    action;
  logic [InWordW-1:0] entry_value;

  modport source (output valid, output action, output entry_value, input ready);
  modport sink   (input valid, input action, input entry_value, output ready);
endinterface

interface csl_res_if import csl_pkg::*; #(
  parameter int unsigned CntW = 5
) ();
  logic               valid;
  logic               ready;
  logic [CntW-1:0]    entry_count;
  logic               has_current;
  logic [InWordW-1:0] current_value;
  logic [StatusW-1:0] status;

  modport source (output valid, output entry_count, output has_current,
                  output current_value, output status, input ready);
  modport sink   (input valid, input entry_count, input has_current,
                  input current_value, input status, output ready);
endinterface

FILE: rtl/core/csl_cell.sv
// One storage cell of a stack chain: holds a word or takes a neighbour's word.
`timescale 1ns / 1ps

module csl_cell import csl_pkg::*; #(
  parameter int unsigned WordW = DefWordWidth
) (
  input  logic              clk_i,
  input  csl_stk_op_e       op_i,
  input  logic [WordW-1:0]  push_i,
  input  logic [WordW-1:0]  pop_i,
  output logic [WordW-1:0]  word_o
);

  logic [WordW-1:0] word_q;
  logic [WordW-1:0] word_d;

  // Select the word this cell holds after the edge.
  always_comb begin
    case (op_i)
      STK_PUSH: word_d = push_i;
      STK_LOAD: word_d = push_i;
      STK_POP:  word_d = pop_i;
      default:  word_d = word_q;
    endcase
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

FILE: rtl/core/csl_stack.sv
// A stack built as a chain of cells; cell 0 is the top of the stack.
`timescale 1ns / 1ps

module csl_stack import csl_pkg::*; #(
  parameter int unsigned Depth = DefCapacity,
  parameter int unsigned WordW = DefWordWidth
) (
  input  logic              clk_i,
  input  csl_stk_op_e       op_i,
  input  logic [WordW-1:0]  word_i,
  output logic [WordW-1:0]  top_o
);

  logic [WordW-1:0] cell_word [Depth];

  for (genvar j = 0; j < Depth; j++) begin : g_cell
    csl_stk_op_e      cell_op;
    logic [WordW-1:0] cell_push;
    logic [WordW-1:0] cell_pop;

    // A load only replaces the top word; deeper cells keep theirs.
    if (j == 0) begin : g_top
      assign cell_op   = op_i;
      assign cell_push = word_i;
    end else begin : g_inner
      assign cell_op   = (op_i == STK_LOAD) ? STK_HOLD : op_i;
      assign cell_push = cell_word[j-1];
    end

    // The deepest cell has nothing below it to pull up.
    if (j == Depth - 1) begin : g_last
      assign cell_pop = cell_word[j];
    end else begin : g_mid
      assign cell_pop = cell_word[j+1];
    end

    csl_cell #(
      .WordW (WordW)
    ) u_cell (
      .clk_i  (clk_i),
      .op_i   (cell_op),
      .push_i (cell_push),
      .pop_i  (cell_pop),
      .word_o (cell_word[j])
    );
  end

  assign top_o = cell_word[0];

endmodule

FILE: rtl/core/cursor_sequence_list.sv
// Top level of the cursor sequence list: sequencer around two cell stacks.
`timescale 1ns / 1ps
//
// Usage: commands arrive on cmd_i (action, entry_value) and each yields one
// result word on res_o (entry_count, has_current, current_value, status).
// A word moves when valid and ready are both high at a rising edge.
// The list is held as two stacks of cells: the right stack holds the
// current word on top and the words after it, the left stack holds the
// words before the cursor with the nearest one on top. On a push or pop
// a stack moves all its cells to a neighbour at the same edge.
// Advance, attach, remove, and insert with a current word give their
// result in the cycle after the command is taken.
// Start, and insert without a current word into a list that is not full,
// first move the left stack into the right stack one word a cycle; insert
// then pushes its word, and the result follows once the left stack is empty.
// Throughput: a new command is taken while the previous result is being
// taken, so commands with no drain run one per cycle while res_o is ready.
// Reset empties the list and clears the cursor and the result valid.
// While the receiver stalls, the result is held and no command is taken.
//

module cursor_sequence_list import csl_pkg::*; #(
  parameter int unsigned CAPACITY   = DefCapacity,
  parameter int unsigned WORD_WIDTH = DefWordWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  csl_cmd_if.sink   cmd_i,
  csl_res_if.source res_o
);

  localparam int unsigned CntW   = $clog2(CAPACITY + 1);
  localparam int unsigned StoreW = (WORD_WIDTH < InWordW) ? WORD_WIDTH : InWordW;

  csl_state_e       state_q, state_d;
  logic [CntW-1:0]  left_cnt_q, left_cnt_d;
  logic [CntW-1:0]  right_cnt_q, right_cnt_d;
  logic             out_valid_q, out_valid_d;
  csl_status_e      status_q, status_d;
  logic             pend_ins_q, pend_ins_d;
  logic [StoreW-1:0] pend_word_q, pend_word_d;

  csl_stk_op_e      left_op, right_op;
  logic [StoreW-1:0] right_in;
  logic [StoreW-1:0] left_top, right_top;
  logic [StoreW-1:0] cmd_word;

  csl_action_e      act;
  logic             cmd_fire;
  logic             has_cur;
  logic             full;
  logic             need_drain;

  // Command decode.
  assign act      = csl_action_e'(cmd_i.action);
  assign cmd_word = cmd_i.entry_value[StoreW-1:0];
  assign cmd_i.ready = (state_q == ST_IDLE) && (!out_valid_q || res_o.ready);
  assign cmd_fire = cmd_i.valid && cmd_i.ready;
  assign has_cur  = (right_cnt_q != '0);
  assign full     = ((left_cnt_q + right_cnt_q) == CntW'(CAPACITY));
  assign need_drain = (left_cnt_q != '0) &&
                      ((act == ACT_START) || ((act == ACT_INSERT) && !has_cur && !full));

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_fire && need_drain) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (left_cnt_q == '0) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Stack operations, counts and result control.
  always_comb begin
    left_op     = STK_HOLD;
    right_op    = STK_HOLD;
    right_in    = cmd_word;
    left_cnt_d  = left_cnt_q;
    right_cnt_d = right_cnt_q;
    status_d    = status_q;
    pend_ins_d  = pend_ins_q;
    pend_word_d = pend_word_q;
    out_valid_d = out_valid_q && !res_o.ready;
    case (state_q)
      ST_IDLE: begin
        if (cmd_fire) begin
          status_d    = STS_OK;
          pend_ins_d  = (act == ACT_INSERT);
          pend_word_d = cmd_word;
          if (!need_drain) begin
            out_valid_d = 1'b1;
          end
          case (act)
            ACT_ADVANCE: begin
              if (!has_cur) begin
                status_d = STS_ADV_NONE;
              end else begin
                left_op     = STK_PUSH;
                right_op    = STK_POP;
                left_cnt_d  = left_cnt_q + 1'b1;
                right_cnt_d = right_cnt_q - 1'b1;
              end
            end
            ACT_INSERT: begin
              if (full) begin
                status_d = STS_FULL;
              end else if (has_cur || (left_cnt_q == '0)) begin
                right_op    = STK_PUSH;
                right_cnt_d = right_cnt_q + 1'b1;
              end
            end
            ACT_ATTACH: begin
              if (full) begin
                status_d = STS_FULL;
              end else if (has_cur) begin
                // Current word moves behind the cursor; the new word replaces it.
                left_op    = STK_PUSH;
                right_op   = STK_LOAD;
                left_cnt_d = left_cnt_q + 1'b1;
              end else begin
                right_op    = STK_PUSH;
                right_cnt_d = right_cnt_q + 1'b1;
              end
            end
            ACT_REMOVE: begin
              if (!has_cur) begin
                status_d = STS_REM_NONE;
              end else begin
                right_op    = STK_POP;
                right_cnt_d = right_cnt_q - 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAIN: begin
        if (left_cnt_q != '0) begin
          // Move the word nearest the cursor onto the right stack.
          left_op     = STK_POP;
          right_op    = STK_PUSH;
          right_in    = left_top;
          left_cnt_d  = left_cnt_q - 1'b1;
          right_cnt_d = right_cnt_q + 1'b1;
        end else begin
          if (pend_ins_q) begin
            right_op    = STK_PUSH;
            right_in    = pend_word_q;
            right_cnt_d = right_cnt_q + 1'b1;
          end
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      left_cnt_q  <= '0;
      right_cnt_q <= '0;
      out_valid_q <= 1'b0;
      pend_ins_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      left_cnt_q  <= left_cnt_d;
      right_cnt_q <= right_cnt_d;
      out_valid_q <= out_valid_d;
      pend_ins_q  <= pend_ins_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    pend_word_q <= pend_word_d;
  end

  // Words before the cursor, nearest on top.
  csl_stack #(
    .Depth (CAPACITY),
    .WordW (StoreW)
  ) u_left (
    .clk_i  (clk_i),
    .op_i   (left_op),
    .word_i (right_top),
    .top_o  (left_top)
  );

  // Current word on top, followed by the rest of the list.
  csl_stack #(
    .Depth (CAPACITY),
    .WordW (StoreW)
  ) u_right (
    .clk_i  (clk_i),
    .op_i   (right_op),
    .word_i (right_in),
    .top_o  (right_top)
  );

  // The result word reflects the list as it stands after the command.
  assign res_o.valid         = out_valid_q;
  assign res_o.entry_count   = left_cnt_q + right_cnt_q;
  assign res_o.has_current   = has_cur;
  assign res_o.current_value = has_cur ? InWordW'(right_top) : '0;
  assign res_o.status        = status_q;

endmodule
